### design/hfc_pkg.sv
// hfc_pkg: shared types and constants of the harmonic feedforward correction block
// register indexes, configuration struct and queued item struct
// no dependencies
package hfc_pkg;

    localparam logic [2:0] REG_AMP_REF    = 3'd0;
    localparam logic [2:0] REG_PHASE_REF  = 3'd1;
    localparam logic [2:0] REG_PHASE_INC  = 3'd2;
    localparam logic [2:0] REG_LIMIT      = 3'd3;
    localparam logic [2:0] REG_ENABLE_X   = 3'd4;
    localparam logic [2:0] REG_ENABLE_Y   = 3'd5;
    localparam logic [2:0] REG_ACTIVE     = 3'd6;

    typedef struct packed {
        logic [15:0] amp_ref;
        logic [15:0] phase_ref;
        logic [15:0] phase_inc;
        logic [22:0] limit;
        logic        enable_x;
        logic        enable_y;
        logic [4:0]  active;
    } hfc_cfg_t;

    typedef struct packed {
        logic        is_load;
        logic [15:0] sample;
        logic        axis;
        logic [3:0]  idx;
        logic [15:0] amp;
        logic [15:0] phase;
    } hfc_item_t;

    typedef struct packed {
        logic      valid;
        hfc_item_t item;
    } hfc_head_t;

endpackage

### design/hfc_ram.sv
// hfc_ram: generic single write port, single read port ram with registered read
// depends on nothing
module hfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

### design/hfc_front.sv
// hfc_front: accepts input items, classifies them and queues them for the back end
// depends on hfc_pkg
module hfc_front #(
    parameter int CORRECTORS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [55:0]       s_tdata,   // sample_value, axis_select, entry_index, entry_amplitude, entry_phase
    input  logic              s_tuser,   // command
    output hfc_pkg::hfc_head_t head,
    input  logic              pop
);
    import hfc_pkg::*;

    hfc_item_t  q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    hfc_item_t  in_item;
    logic       accept;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        in_item.is_load = s_tuser;
        in_item.sample  = s_tdata[15:0];
        in_item.axis    = s_tdata[16];
        in_item.idx     = s_tdata[20:17];
        in_item.amp     = s_tdata[36:21];
        in_item.phase   = s_tdata[52:37];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign accept   = s_tvalid && s_tready;
    // loads beyond the table are dropped here
    assign push     = accept && !(in_item.is_load && (6'(in_item.idx) >= 6'(CORRECTORS)));
    assign do_pop   = pop && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = do_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_item;
        end
    end
endmodule

### design/hfc_cos.sv
// hfc_cos: pipelined fixed-point cosine, one angle per cycle, sixteen stages
// carries a sample alongside the angle; depends on nothing
module hfc_cos (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [15:0]        in_ang,
    input  logic [15:0]        in_side,
    output logic               out_vld,
    output logic signed [16:0] out_cos,
    output logic [15:0]        out_side
);
    localparam logic [30:0] HALF_PI = 31'd1686629713;
    localparam logic [31:0] R90 = 32'd47721858;
    localparam logic [31:0] R56 = 32'd76695844;
    localparam logic [31:0] R30 = 32'd143165576;
    localparam logic [31:0] R12 = 32'd357913941;
    localparam logic [30:0] ONE = 31'h4000_0000;
    localparam int NST = 16;

    typedef struct packed {
        logic        neg;
        logic [15:0] side;
        logic [31:0] t2;
        logic [31:0] w;
        logic [31:0] q;
        logic [30:0] p;
    } cst_t;

    cst_t           st_reg [NST];
    logic [NST-1:0] vld_reg;

    logic [14:0] xx;
    logic [45:0] th_prod;
    logic [61:0] sq_prod;
    logic [30:0] h0;
    logic [30:0] c0;
    logic [16:0] q15;

    function automatic logic [31:0] recip(input logic [31:0] v, input logic [31:0] r);
        logic [63:0] pr;
        begin
            pr = 64'(v) * 64'(r);
            recip = pr[63:32];
        end
    endfunction

    function automatic logic [30:0] fix_p(input logic [31:0] v, input logic [31:0] q0,
                                          input logic [6:0] d);
        logic [31:0] rem;
        logic [31:0] qq;
        begin
            rem   = v - q0 * 32'(d);
            qq    = (rem >= 32'(d)) ? q0 + 32'd1 : q0;
            fix_p = ONE - 31'(qq);
        end
    endfunction

    function automatic logic [31:0] mul_p(input logic [31:0] t2, input logic [30:0] p);
        logic [62:0] pr;
        begin
            pr    = 63'(t2) * 63'(p);
            mul_p = pr[61:30];
        end
    endfunction

    assign xx      = in_ang[14] ? 15'(15'd16384 - {1'b0, in_ang[13:0]}) : {1'b0, in_ang[13:0]};
    assign th_prod = 46'(st_reg[0].w[14:0]) * 46'(HALF_PI);
    assign sq_prod = 62'(st_reg[1].w[30:0]) * 62'(st_reg[1].w[30:0]);
    assign h0      = st_reg[14].w[31:1];
    assign c0      = (h0 >= ONE) ? 31'd0 : ONE - h0;
    assign q15     = 17'((c0 + 31'h4000) >> 15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 1; i < NST; i++)
        begin
            st_reg[i] <= st_reg[i-1];
        end
        st_reg[0].neg  <= in_ang[15] ^ in_ang[14];
        st_reg[0].side <= in_side;
        st_reg[0].w    <= 32'(xx);
        st_reg[0].t2   <= '0;
        st_reg[0].q    <= '0;
        st_reg[0].p    <= '0;
        st_reg[1].w    <= 32'(th_prod[44:14]);
        st_reg[2].t2   <= sq_prod[61:30];
        st_reg[3].q    <= recip(st_reg[2].t2, R90);
        st_reg[4].p    <= fix_p(st_reg[3].t2, st_reg[3].q, 7'd90);
        st_reg[5].w    <= mul_p(st_reg[4].t2, st_reg[4].p);
        st_reg[6].q    <= recip(st_reg[5].w, R56);
        st_reg[7].p    <= fix_p(st_reg[6].w, st_reg[6].q, 7'd56);
        st_reg[8].w    <= mul_p(st_reg[7].t2, st_reg[7].p);
        st_reg[9].q    <= recip(st_reg[8].w, R30);
        st_reg[10].p   <= fix_p(st_reg[9].w, st_reg[9].q, 7'd30);
        st_reg[11].w   <= mul_p(st_reg[10].t2, st_reg[10].p);
        st_reg[12].q   <= recip(st_reg[11].w, R12);
        st_reg[13].p   <= fix_p(st_reg[12].w, st_reg[12].q, 7'd12);
        st_reg[14].w   <= mul_p(st_reg[13].t2, st_reg[13].p);
        st_reg[15].w   <= 32'(st_reg[14].neg ? 17'(-q15) : q15);
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_cos  = $signed(st_reg[NST-1].w[16:0]);
    assign out_side = st_reg[NST-1].side;
endmodule

### design/hfc_div.sv
// hfc_div: magnitude scaling, |acc|*|amp|*2 rounded over the denominator
// partial products then restoring division, quotient capped at 24 bits; no dependencies
module hfc_div #(
    parameter int MAGW = 37,
    parameter int DW   = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MAGW-1:0] acc_mag,
    input  logic [15:0]     amp_mag,
    input  logic [DW-1:0]   den,
    output logic            done,
    output logic [23:0]     mag
);
    localparam int WW = DW + 24;
    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_LO   = 3'd1;
    localparam logic [2:0] D_HI   = 3'd2;
    localparam logic [2:0] D_RND  = 3'd3;
    localparam logic [2:0] D_CHK  = 3'd4;
    localparam logic [2:0] D_DIV  = 3'd5;

    logic [2:0]    state_reg;
    logic [4:0]    step_reg;
    logic [63:0]   a_reg;
    logic [15:0]   amp_reg;
    logic [DW-1:0] den_reg;
    logic [WW-1:0] n_reg;
    logic [WW-1:0] dsh_reg;
    logic [23:0]   q_reg;
    logic          done_reg;
    logic [47:0]   lo_prod;
    logic [47:0]   hi_prod;
    logic [79:0]   hi_sh;
    logic          ge;

    assign lo_prod = 48'(a_reg[31:0]) * 48'(amp_reg);
    assign hi_prod = 48'(a_reg[63:32]) * 48'(amp_reg);
    assign hi_sh   = {hi_prod, 32'd0};
    assign ge      = (n_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_LO;
                    end
                end
                D_LO:  state_reg <= D_HI;
                D_HI:  state_reg <= D_RND;
                D_RND: state_reg <= D_CHK;
                D_CHK:
                begin
                    if (n_reg >= (WW'(den_reg) << 24))
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= D_DIV;
                    end
                end
                D_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        state_reg <= D_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                a_reg   <= 64'(acc_mag);
                amp_reg <= amp_mag;
                den_reg <= den;
            end
            D_LO:  n_reg <= WW'(lo_prod);
            D_HI:  n_reg <= n_reg + WW'(hi_sh);
            D_RND: n_reg <= (n_reg << 1) + WW'(den_reg >> 1);
            D_CHK:
            begin
                q_reg    <= 24'hFF_FFFF;
                dsh_reg  <= WW'(den_reg) << 23;
                step_reg <= 5'd23;
            end
            D_DIV:
            begin
                if (ge)
                begin
                    n_reg <= n_reg - dsh_reg;
                end
                q_reg    <= {q_reg[22:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - 5'd1;
            end
            default: n_reg <= n_reg;
        endcase
    end

    assign done = done_reg;
    assign mag  = q_reg;
endmodule

### design/hfc_back.sv
// hfc_back: executes queued items: table loads, window update, per-corrector correlation
// and scaling, limit check and result output; uses hfc_pkg, hfc_ram, hfc_cos, hfc_div
module hfc_back #(
    parameter int TAPS       = 64,
    parameter int CORRECTORS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hfc_pkg::hfc_cfg_t  cfg,
    input  hfc_pkg::hfc_head_t head,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_axis,
    output logic [3:0]         m_corrector,
    output logic [23:0]        m_correction,
    output logic               m_too_high,
    output logic               m_last
);
    import hfc_pkg::*;

    localparam int TW   = $clog2(2 * CORRECTORS);
    localparam int WAW  = $clog2(TAPS);
    localparam int KW   = $clog2(TAPS + 1);
    localparam int NCW  = (CORRECTORS > 1) ? $clog2(CORRECTORS) : 1;
    localparam int MAGW = $clog2(TAPS + 1) + 30;
    localparam int AW   = MAGW + 1;
    localparam int DW   = $clog2(TAPS) + 26;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TBL    = 3'd1;
    localparam logic [2:0] S_TWAIT  = 3'd2;
    localparam logic [2:0] S_STREAM = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic           axis_reg, axis_next;
    logic [NCW-1:0] n_reg, n_next;
    logic           over_reg, over_next;
    logic [WAW-1:0] wptr_reg;
    logic [WAW-1:0] newest_reg;
    logic [KW-1:0]  fill_reg;
    logic [WAW-1:0] rptr_reg;
    logic [KW-1:0]  k_reg;
    logic [15:0]    ang_reg;
    logic signed [15:0] amp_reg;
    logic [DW-1:0]  den_reg;
    logic           iss_vld_reg;
    logic [15:0]    iss_ang_reg;
    logic           iss_live_reg;
    logic signed [31:0] prod_reg;
    logic           pv_reg;
    logic signed [AW-1:0] acc_reg;
    logic [KW-1:0]  mac_cnt_reg;
    logic [23:0]    mag_reg [CORRECTORS];
    logic [CORRECTORS-1:0] neg_reg;
    logic           out_vld_reg;
    logic           out_axis_reg;
    logic [3:0]     out_corr_reg;
    logic [23:0]    out_val_reg;
    logic           out_high_reg;
    logic           out_last_reg;

    logic [5:0]     nact;
    logic           n_is_last;
    logic           is_sample;
    logic           is_load;
    logic           tbl_we;
    logic [TW-1:0]  tbl_waddr;
    logic [TW-1:0]  tbl_raddr;
    logic [31:0]    tbl_rdata;
    logic           win_we;
    logic [15:0]    win_rdata;
    logic           cos_vld;
    logic signed [16:0] cos_val;
    logic [15:0]    cos_side;
    logic           div_start;
    logic           div_done;
    logic [23:0]    div_mag;
    logic [MAGW-1:0] acc_mag;
    logic [15:0]    amp_mag;
    logic [15:0]    amp_eff;
    logic           emit_go;

    assign nact      = (6'(cfg.active) > 6'(CORRECTORS)) ? 6'(CORRECTORS) : 6'(cfg.active);
    assign n_is_last = (6'(n_reg) == nact - 6'd1);
    assign is_sample = (state_reg == S_IDLE) && head.valid && !head.item.is_load;
    assign is_load   = (state_reg == S_IDLE) && head.valid && head.item.is_load;
    assign pop       = is_sample || is_load;
    assign tbl_we    = is_load;
    assign tbl_waddr = TW'(head.item.axis) * TW'(CORRECTORS) + TW'(head.item.idx);
    assign tbl_raddr = TW'(axis_reg) * TW'(CORRECTORS) + TW'(n_reg);
    assign win_we    = is_sample;
    assign div_start = (state_reg == S_DRAIN) && (mac_cnt_reg == KW'(TAPS));
    assign acc_mag   = MAGW'(acc_reg[AW-1] ? -acc_reg : acc_reg);
    assign amp_mag   = amp_reg[15] ? 16'(-amp_reg) : 16'(amp_reg);
    assign amp_eff   = (cfg.amp_ref == 16'd0) ? 16'd1 : cfg.amp_ref;
    assign emit_go   = (state_reg == S_EMIT) && (!out_vld_reg || m_tready);

    hfc_ram #(.WIDTH(32), .DEPTH(2 * CORRECTORS)) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata ({head.item.amp, head.item.phase}),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    hfc_ram #(.WIDTH(16), .DEPTH(TAPS)) u_win (
        .clk   (clk),
        .we    (win_we),
        .waddr (wptr_reg),
        .wdata (head.item.sample),
        .raddr (rptr_reg),
        .rdata (win_rdata)
    );

    hfc_cos u_cos (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (iss_vld_reg),
        .in_ang   (iss_ang_reg),
        .in_side  (iss_live_reg ? win_rdata : 16'd0),
        .out_vld  (cos_vld),
        .out_cos  (cos_val),
        .out_side (cos_side)
    );

    hfc_div #(.MAGW(MAGW), .DW(DW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .acc_mag (acc_mag),
        .amp_mag (amp_mag),
        .den     (den_reg),
        .done    (div_done),
        .mag     (div_mag)
    );

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        n_next     = n_reg;
        over_next  = over_reg;
        case (state_reg)
            S_IDLE:
            begin
                n_next    = '0;
                over_next = 1'b0;
                if (is_sample && (nact != 6'd0))
                begin
                    if (cfg.enable_x)
                    begin
                        axis_next  = 1'b0;
                        state_next = S_TBL;
                    end
                    else if (cfg.enable_y)
                    begin
                        axis_next  = 1'b1;
                        state_next = S_TBL;
                    end
                end
            end
            S_TBL:   state_next = S_TWAIT;
            S_TWAIT: state_next = S_STREAM;
            S_STREAM:
            begin
                if (k_reg == KW'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_mag > 24'(cfg.limit))
                    begin
                        over_next = 1'b1;
                    end
                    if (n_is_last)
                    begin
                        n_next     = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = S_TBL;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    if (n_is_last)
                    begin
                        n_next = '0;
                        if (!axis_reg && cfg.enable_y)
                        begin
                            axis_next  = 1'b1;
                            over_next  = 1'b0;
                            state_next = S_TBL;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            axis_reg     <= 1'b0;
            n_reg        <= '0;
            over_reg     <= 1'b0;
            wptr_reg     <= '0;
            newest_reg   <= '0;
            fill_reg     <= '0;
            iss_vld_reg  <= 1'b0;
            pv_reg       <= 1'b0;
            mac_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            n_reg       <= n_next;
            over_reg    <= over_next;
            iss_vld_reg <= (state_reg == S_STREAM);
            pv_reg      <= cos_vld;
            if (win_we)
            begin
                newest_reg <= wptr_reg;
                wptr_reg   <= (wptr_reg == WAW'(TAPS - 1)) ? '0 : wptr_reg + 1'b1;
                if (fill_reg != KW'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (state_reg == S_TWAIT)
            begin
                mac_cnt_reg <= '0;
            end
            else if (pv_reg)
            begin
                mac_cnt_reg <= mac_cnt_reg + 1'b1;
            end
            if (emit_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            den_reg <= DW'(TAPS * 1024) * DW'(amp_eff);
        end
        if (state_reg == S_TWAIT)
        begin
            amp_reg  <= $signed(tbl_rdata[31:16]);
            ang_reg  <= cfg.phase_ref - tbl_rdata[15:0];
            rptr_reg <= newest_reg;
            k_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (pv_reg)
            begin
                acc_reg <= acc_reg + AW'(prod_reg);
            end
            if (state_reg == S_STREAM)
            begin
                ang_reg  <= ang_reg + cfg.phase_inc;
                rptr_reg <= (rptr_reg == '0) ? WAW'(TAPS - 1) : rptr_reg - 1'b1;
                k_reg    <= k_reg + 1'b1;
            end
        end
        iss_ang_reg  <= ang_reg;
        iss_live_reg <= (k_reg < fill_reg);
        prod_reg     <= 32'(cos_val * $signed(cos_side));
        if ((state_reg == S_DIV) && div_done)
        begin
            mag_reg[n_reg] <= div_mag;
            neg_reg[n_reg] <= acc_reg[AW-1] ^ amp_reg[15];
        end
        if (emit_go)
        begin
            out_axis_reg <= axis_reg;
            out_corr_reg <= 4'(n_reg);
            out_high_reg <= over_reg;
            out_last_reg <= n_is_last && (axis_reg || !cfg.enable_y);
            if (over_reg)
            begin
                out_val_reg <= 24'd0;
            end
            else
            begin
                out_val_reg <= neg_reg[n_reg] ? 24'(-mag_reg[n_reg]) : mag_reg[n_reg];
            end
        end
    end

    assign m_tvalid     = out_vld_reg;
    assign m_axis       = out_axis_reg;
    assign m_corrector  = out_corr_reg;
    assign m_correction = out_val_reg;
    assign m_too_high   = out_high_reg;
    assign m_last       = out_last_reg;
endmodule

### design/harmonic_feedforward_correction.sv
// harmonic_feedforward_correction: a load item writes one table entry; a sample item
// is correlated for each active corrector of each enabled axis, then one result per corrector is emitted,
// using the one-tap-per-cycle cosine and multiply-accumulate pipeline and the 24-step divider
// input queue holds two items so input is taken while results drain
// reset: registers to defaults, window reads zero until filled, tables undefined until loaded
module harmonic_feedforward_correction #(
    parameter int TAPS       = 64,
    parameter int CORRECTORS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample_value, axis_select, entry_index, entry_amplitude, entry_phase
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // corrector, correction
    output logic [1:0]  m_tuser,   // axis, too_high
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_wdata
);
    import hfc_pkg::*;

    hfc_cfg_t   cfg_reg;
    hfc_head_t  head;
    logic       pop;
    logic       o_axis;
    logic [3:0] o_corr;
    logic [23:0] o_val;
    logic       o_high;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amp_ref   <= 16'd1;
            cfg_reg.phase_ref <= 16'd0;
            cfg_reg.phase_inc <= 16'd0;
            cfg_reg.limit     <= 23'd104858;
            cfg_reg.enable_x  <= 1'b0;
            cfg_reg.enable_y  <= 1'b0;
            cfg_reg.active    <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AMP_REF:   cfg_reg.amp_ref   <= cfg_wdata[15:0];
                REG_PHASE_REF: cfg_reg.phase_ref <= cfg_wdata[15:0];
                REG_PHASE_INC: cfg_reg.phase_inc <= cfg_wdata[15:0];
                REG_LIMIT:     cfg_reg.limit     <= cfg_wdata;
                REG_ENABLE_X:  cfg_reg.enable_x  <= cfg_wdata[0];
                REG_ENABLE_Y:  cfg_reg.enable_y  <= cfg_wdata[0];
                REG_ACTIVE:    cfg_reg.active    <= cfg_wdata[4:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    hfc_front #(.CORRECTORS(CORRECTORS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    hfc_back #(.TAPS(TAPS), .CORRECTORS(CORRECTORS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_axis       (o_axis),
        .m_corrector  (o_corr),
        .m_correction (o_val),
        .m_too_high   (o_high),
        .m_last       (m_tlast)
    );

    assign m_tdata = {4'd0, o_val, o_corr};
    assign m_tuser = {o_high, o_axis};
endmodule
